// ----- rtl/core/lru_set_assoc_cache_timing_defines.svh -----
// Assertion helpers for the cache timing block.
// In synthesis builds the macros expand to nothing.
`ifndef LRU_SET_ASSOC_CACHE_TIMING_DEFINES_SVH
`define LRU_SET_ASSOC_CACHE_TIMING_DEFINES_SVH

`ifndef SYNTHESIS

`define LSAC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsac: same-cycle check failed");

`define LSAC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsac: next-cycle check failed");

`else

`define LSAC_ASSERT_IMPL(lbl, ante, cons)
`define LSAC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/lsac_pkg.sv -----
package lsac_pkg;

	// config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SETS_LOG     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOC  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_THRU   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIT_CYCLES   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_CYCLES   = 3'd6;

	// reset values of the registers
	localparam logic [3:0] RST_SETS_LOG     = 4'd6;
	localparam logic [3:0] RST_WAYS_USED    = 4'd8;
	localparam logic [3:0] RST_BLOCK_OFFSET = 4'd4;
	localparam logic       RST_WRITE_ALLOC  = 1'b1;
	localparam logic       RST_WRITE_THRU   = 1'b0;
	localparam logic [7:0] RST_HIT_CYCLES   = 8'd1;
	localparam logic [7:0] RST_MEM_CYCLES   = 8'd100;

	// cost arithmetic: 255 << 13 twice plus two bytes fits in 23 bits
	localparam int CYC_W  = 20;
	localparam int COST_W = 23;
	localparam logic [CYC_W-1:0] CYCLE_MAX = {CYC_W{1'b1}};

	// status of the way scan
	typedef struct packed {
		logic done;
		logic hit;
		logic inv;
	} scan_flags_t;

endpackage

// ----- rtl/core/lsac_dir.sv -----
// Directory store: one row per set, all ways of the set side by side.
// Per-row valid flops make a never-written row read as all zero.
module lsac_dir
	import lsac_pkg::*;
#(
	parameter int SETS  = 256,
	parameter int SET_W = 8,
	parameter int ROW_W = 280
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [SET_W-1:0] rd_set,
	output logic [ROW_W-1:0] rd_row,
	input  logic             wr_en,
	input  logic [SET_W-1:0] wr_set,
	input  logic [ROW_W-1:0] wr_row
);

	logic [ROW_W-1:0] mem [SETS];
	logic [SETS-1:0]  row_vld_q;
	logic [ROW_W-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_set] <= wr_row;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_set];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_set] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_set];
			end
		end
	end

	assign rd_row = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- rtl/core/lsac_scan.sv -----
// Way scanner: one shared tag comparator walks the ways of a row, one per
// cycle, tracking first hit, first invalid way and highest-rank way.
module lsac_scan
	import lsac_pkg::*;
#(
	parameter int WAYS   = 8,
	parameter int TAG_W  = 30,
	parameter int RANK_W = 3,
	parameter int WAY_W  = 3,
	parameter int CNT_W  = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [WAYS*(TAG_W+2+RANK_W)-1:0] row,
	input  logic [TAG_W-1:0]                tag,
	input  logic [CNT_W-1:0]                nways,
	output scan_flags_t                     flags,
	output logic [WAY_W-1:0]                hit_way,
	output logic [WAY_W-1:0]                inv_way,
	output logic [WAY_W-1:0]                vic_way
);

	localparam int ENT_W = TAG_W + 2 + RANK_W;

	logic              run_q;
	logic              done_q;
	logic              hit_q;
	logic              inv_q;
	logic [WAY_W-1:0]  way_q;
	logic [WAY_W-1:0]  hway_q;
	logic [WAY_W-1:0]  iway_q;
	logic [WAY_W-1:0]  vway_q;
	logic [RANK_W-1:0] vrank_q;

	logic [ENT_W-1:0]  ent;
	logic              e_valid;
	logic [RANK_W-1:0] e_rank;
	logic              tag_eq;
	logic              last;

	assign ent     = row[ENT_W*way_q +: ENT_W];
	assign e_valid = ent[RANK_W+1];
	assign e_rank  = ent[RANK_W-1:0];
	assign tag_eq  = e_valid && (ent[ENT_W-1 -: TAG_W] == tag);
	assign last    = (CNT_W'(way_q) + CNT_W'(1)) == nways;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
			inv_q   <= 1'b0;
			way_q   <= '0;
			hway_q  <= '0;
			iway_q  <= '0;
			vway_q  <= '0;
			vrank_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			hit_q  <= 1'b0;
			inv_q  <= 1'b0;
			way_q  <= '0;
		end else if (run_q) begin
			// lowest matching way wins
			if (!hit_q && tag_eq) begin
				hit_q  <= 1'b1;
				hway_q <= way_q;
			end
			if (!inv_q && !e_valid) begin
				inv_q  <= 1'b1;
				iway_q <= way_q;
			end
			// strictly greater keeps the lowest way on a tie
			if (way_q == '0 || e_rank > vrank_q) begin
				vway_q  <= way_q;
				vrank_q <= e_rank;
			end
			if (last) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				way_q <= way_q + WAY_W'(1);
			end
		end
	end

	assign flags.done = done_q;
	assign flags.hit  = hit_q;
	assign flags.inv  = inv_q;
	assign hit_way    = hway_q;
	assign inv_way    = iway_q;
	assign vic_way    = vway_q;

endmodule

// ----- rtl/core/lru_set_assoc_cache_timing.sv -----
// Set-associative cache directory timing model with true LRU replacement.
// Each item on the input channel is a read or write at a byte address; each
// produces exactly one result item with the hit flag, the access cost in
// cycles (saturating at 20 bits) and whether a dirty victim was written back.
// One item is processed at a time, in these steps: accept, directory row
// read, a walk over the ways in use (ways_used clamped to 1..WAYS) through
// the shared tag comparator, closing the scan, and a read-modify-write that
// updates the row and loads the result register. The result sits in an
// output register, so a new item is accepted while the last result waits;
// the update cycle holds only if the output register is still full.
// The directory needs no clearing pass: each set row has a valid flop that
// reset clears, and an unwritten row reads as empty. Configuration writes are
// always taken and must only be issued while the block is idle.

`include "lru_set_assoc_cache_timing_defines.svh"

module lru_set_assoc_cache_timing
	import lsac_pkg::*;
#(
	parameter int MAX_SETS     = 256,
	parameter int WAYS         = 8,
	parameter int ADDRESS_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration writes
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// access items
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    op,
	input  logic [ADDRESS_BITS-1:0] address,
	// result items
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    hit,
	output logic [CYC_W-1:0]        cycles,
	output logic                    wrote_back
);

	localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int SL_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W = WAY_W;
	localparam int CNT_W  = $clog2(WAYS + 1);
	localparam int TAG_W  = ADDRESS_BITS - 2;
	localparam int ENT_W  = TAG_W + 2 + RANK_W;
	localparam int ROW_W  = WAYS * ENT_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_UPD  = 2'd3;

	// configuration registers
	logic [3:0] sets_log_q;
	logic [3:0] ways_used_q;
	logic [3:0] block_off_q;
	logic       wr_alloc_q;
	logic       wr_thru_q;
	logic [7:0] hit_cyc_q;
	logic [7:0] mem_cyc_q;

	// sequencer and item registers
	logic [1:0]       state_q;
	logic             op_q;
	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;

	// result register
	logic             out_valid_q;
	logic             hit_q;
	logic [CYC_W-1:0] cycles_q;
	logic             wb_q;

	// effective geometry
	logic [3:0]       sl_eff;
	logic [3:0]       ob_eff;
	logic [CNT_W-1:0] nways_eff;
	logic [SET_W-1:0] set_in;
	logic [TAG_W-1:0] tag_in;
	logic [4:0]       tag_sh;

	// directory and scan
	logic [ROW_W-1:0] row;
	logic [ROW_W-1:0] new_row;
	logic             dir_wr_en;
	scan_flags_t      sflags;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] inv_way;
	logic [WAY_W-1:0] vic_way;

	// update stage
	logic              in_acc;
	logic              go;
	logic              miss_noalloc;
	logic              do_wr;
	logic              fill;
	logic              wb;
	logic              mark_dirty;
	logic [WAY_W-1:0]  tgt_way;
	logic [ENT_W-1:0]  tgt_ent;
	logic [RANK_W-1:0] old_rank;
	logic [COST_W-1:0] wm;
	logic [COST_W-1:0] cost;
	logic [CYC_W-1:0]  cost_sat;

	// ---------------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sets_log_q  <= RST_SETS_LOG;
			ways_used_q <= RST_WAYS_USED;
			block_off_q <= RST_BLOCK_OFFSET;
			wr_alloc_q  <= RST_WRITE_ALLOC;
			wr_thru_q   <= RST_WRITE_THRU;
			hit_cyc_q   <= RST_HIT_CYCLES;
			mem_cyc_q   <= RST_MEM_CYCLES;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SETS_LOG:     sets_log_q  <= cfg_data[3:0];
				REG_WAYS_USED:    ways_used_q <= cfg_data[3:0];
				REG_BLOCK_OFFSET: block_off_q <= cfg_data[3:0];
				REG_WRITE_ALLOC:  wr_alloc_q  <= cfg_data[0];
				REG_WRITE_THRU:   wr_thru_q   <= cfg_data[0];
				REG_HIT_CYCLES:   hit_cyc_q   <= cfg_data;
				REG_MEM_CYCLES:   mem_cyc_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// geometry clamps and address split
	// ---------------------------------------------------------------------
	assign sl_eff = (sets_log_q > 4'(SL_MAX)) ? 4'(SL_MAX) : sets_log_q;
	assign ob_eff = (block_off_q < 4'd2) ? 4'd2 : block_off_q;

	always_comb begin
		if (ways_used_q == 4'd0) begin
			nways_eff = CNT_W'(1);
		end else if ({1'b0, ways_used_q} > 5'(WAYS)) begin
			nways_eff = CNT_W'(WAYS);
		end else begin
			nways_eff = CNT_W'(ways_used_q);
		end
	end

	assign tag_sh = {1'b0, ob_eff} + {1'b0, sl_eff};
	assign set_in = SET_W'(address >> ob_eff) & ~({SET_W{1'b1}} << sl_eff);
	assign tag_in = TAG_W'(address >> tag_sh);

	// ---------------------------------------------------------------------
	// sequencer: accept, read row, scan ways, update row and result
	// ---------------------------------------------------------------------
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign go       = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_acc) state_q <= S_READ;
				S_READ: state_q <= S_SCAN;
				S_SCAN: if (sflags.done) state_q <= S_UPD;
				S_UPD:  if (go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= op;
			set_q <= set_in;
			tag_q <= tag_in;
		end
	end

	lsac_dir #(
		.SETS  (MAX_SETS),
		.SET_W (SET_W),
		.ROW_W (ROW_W)
	) u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (state_q == S_READ),
		.rd_set (set_q),
		.rd_row (row),
		.wr_en  (dir_wr_en),
		.wr_set (set_q),
		.wr_row (new_row)
	);

	// scan starts with the row read; the row is there when the scan runs
	lsac_scan #(
		.WAYS   (WAYS),
		.TAG_W  (TAG_W),
		.RANK_W (RANK_W),
		.WAY_W  (WAY_W),
		.CNT_W  (CNT_W)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_READ),
		.row     (row),
		.tag     (tag_q),
		.nways   (nways_eff),
		.flags   (sflags),
		.hit_way (hit_way),
		.inv_way (inv_way),
		.vic_way (vic_way)
	);

	// ---------------------------------------------------------------------
	// update: pick target way, age ranks, compute cost
	// ---------------------------------------------------------------------
	assign miss_noalloc = !sflags.hit && op_q && !wr_alloc_q;
	assign do_wr        = !miss_noalloc;
	assign fill         = !sflags.hit && sflags.inv;
	assign tgt_way      = sflags.hit ? hit_way : (sflags.inv ? inv_way : vic_way);
	assign tgt_ent      = row[ENT_W*tgt_way +: ENT_W];
	assign old_rank     = tgt_ent[RANK_W-1:0];
	assign mark_dirty   = op_q && !wr_thru_q;
	// a dirty line evicted under write-through is dropped silently
	assign wb           = do_wr && !sflags.hit && !sflags.inv && tgt_ent[RANK_W] && !wr_thru_q;
	assign dir_wr_en    = (state_q == S_UPD) && go && do_wr;

	always_comb begin
		logic [ENT_W-1:0]  e;
		logic [RANK_W-1:0] rk;
		new_row = row;
		for (int i = 0; i < WAYS; i++) begin
			e  = row[i*ENT_W +: ENT_W];
			rk = e[RANK_W-1:0];
			if (CNT_W'(i) < nways_eff) begin
				if (WAY_W'(i) == tgt_way) begin
					if (!sflags.hit) begin
						e[ENT_W-1 -: TAG_W] = tag_q;
						e[RANK_W+1]         = 1'b1;
						e[RANK_W]           = mark_dirty;
					end else begin
						e[RANK_W] = e[RANK_W] | mark_dirty;
					end
					e[RANK_W-1:0] = '0;
				end else if (e[RANK_W+1] && (fill || rk < old_rank) &&
						rk < RANK_W'(WAYS - 1)) begin
					e[RANK_W-1:0] = rk + RANK_W'(1);
				end
			end
			new_row[i*ENT_W +: ENT_W] = e;
		end
	end

	// words per block times word cost is a shift
	assign wm = COST_W'(mem_cyc_q) << (ob_eff - 4'd2);

	always_comb begin
		logic [COST_W-1:0] t_wm;
		logic [COST_W-1:0] t_h;
		logic [COST_W-1:0] t_m;
		logic [COST_W-1:0] t_wb;
		t_wm = (!sflags.hit && do_wr) ? wm : '0;
		t_h  = miss_noalloc ? '0 : COST_W'(hit_cyc_q);
		t_m  = (miss_noalloc || (op_q && wr_thru_q)) ? COST_W'(mem_cyc_q) : '0;
		t_wb = wb ? wm : '0;
		cost = t_wm + t_h + t_m + t_wb;
	end

	assign cost_sat = (cost > COST_W'(CYCLE_MAX)) ? CYCLE_MAX : cost[CYC_W-1:0];

	// ---------------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_UPD && go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD && go) begin
			hit_q    <= sflags.hit;
			cycles_q <= cost_sat;
			wb_q     <= wb;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign cycles     = cycles_q;
	assign wrote_back = wb_q;

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	`LSAC_ASSERT_IMPL(a_result_from_update, $rose(out_valid_q), $past(state_q) == S_UPD)
	`LSAC_ASSERT_IMPL(a_wb_only_on_miss, out_valid_q && wb_q, !hit_q)
	`LSAC_ASSERT_NEXT(a_accept_reads_row, in_valid && in_ready, state_q == S_READ)

endmodule
